>>> rtl/sscp_pkg.sv
// Shared types, widths and constants for the servo sweep pacing block.
// Also holds the elaboration-time cosine quadrant evaluator used to fill the
// pacing table. No dependencies.
package sscp_pkg;

   localparam int unsigned POS_W        = 12;
   localparam int unsigned ANGLE_W      = 8;
   localparam int unsigned DELAY_W      = 16;
   localparam int unsigned WEIGHT_W     = 16;
   localparam int unsigned MUL_W        = 16;
   localparam int unsigned ANGLE_PROD_W = POS_W + ANGLE_W;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned ANGLE_FULL   = 180;

   // 1 + cos is carried as 32768 + c, c in Q1.15
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

   localparam logic [63:0] Q30_ONE      = 64'd1073741824;
   localparam logic [63:0] Q30_TWO_PI   = 64'd6746518852;
   localparam logic [63:0] Q30_PI       = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_S,
      ST_DIV_S,
      ST_MUL_E,
      ST_DIV_E,
      ST_MOVE,
      ST_INDEX,
      ST_PHASE,
      ST_SCALE,
      ST_RESP
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE = 3'd0,
      CSR_MAX_PULSE = 3'd1,
      CSR_START_ANG = 3'd2,
      CSR_END_ANG   = 3'd3,
      CSR_MIN_DELAY = 3'd4,
      CSR_MAX_DELAY = 3'd5,
      CSR_ENABLE    = 3'd6
   } csr_index_type;

   // Cosine of a Q30 angle in [0, pi/2], Taylor series through x^14,
   // rounded to Q15 and capped below one.
   function automatic logic [WEIGHT_W-1:0] cos_quadrant(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      int                 k;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = $signed(Q30_ONE);
      for (k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > $signed(Q30_ONE)) begin
         sum = $signed(Q30_ONE);
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
         sum = 64'sd32767;
      end
      return sum[WEIGHT_W-1:0];
   endfunction

endpackage

>>> rtl/servo_sweep_cosine_pacing.sv
// Servo sweep with raised-cosine pacing. Each req beat is either a restart,
// which reloads the position with the start pulse width, or a step, which,
// while enabled and unless the start and end widths are equal, moves the
// position one microsecond toward the current end of the sweep and reports
// the wait before the next step. One item is worked at a time; a rsp beat
// that is still stalled does not block acceptance of the next req. A full
// step computes both angle-to-width mappings, the phase index and the delay
// scaling in turn on the shared bit-serial multiplier and the shared
// bit-serial divider, which is max(20, 12 + clog2(COS_TABLE_SIZE + 1)) bits
// wide (21 by default); a restart computes only the start mapping, a step
// while disabled none. The cosine table is a constant ROM built at
// elaboration. Registers are written over the csr port, which is always
// ready; write it only while the block is idle.
module servo_sweep_cosine_pacing #(
   parameter int COS_TABLE_SIZE = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sscp_pkg::POS_W-1:0]           rsp_position_us,
   output logic [sscp_pkg::DELAY_W-1:0]         rsp_step_delay_us,
   output logic                                 rsp_active,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sscp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sscp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int POS_W    = sscp_pkg::POS_W;
   localparam int ANGLE_W  = sscp_pkg::ANGLE_W;
   localparam int DELAY_W  = sscp_pkg::DELAY_W;
   localparam int WEIGHT_W = sscp_pkg::WEIGHT_W;
   localparam int MUL_W    = sscp_pkg::MUL_W;
   localparam int IDX_W    = (COS_TABLE_SIZE > 1) ? $clog2(COS_TABLE_SIZE) : 1;
   localparam int NUM_RAW  = POS_W + $clog2(COS_TABLE_SIZE + 1);
   localparam int NUM_W    = (NUM_RAW > sscp_pkg::ANGLE_PROD_W) ?
                             NUM_RAW : sscp_pkg::ANGLE_PROD_W;
   localparam int ROM_W    = COS_TABLE_SIZE * WEIGHT_W;

   // each entry holds 32768 + cos(2*pi*i/N) in Q1.15
   function automatic logic [ROM_W-1:0] build_cos_rom();
      logic [ROM_W-1:0]    rom;
      logic [63:0]         j;
      logic [63:0]         th;
      logic [WEIGHT_W-1:0] cq;
      int                  i;
      rom = '0;
      for (i = 0; i < COS_TABLE_SIZE; i++) begin
         j = 64'(i);
         if (2 * j > 64'(COS_TABLE_SIZE)) begin
            j = 64'(COS_TABLE_SIZE) - j;
         end
         th = j * sscp_pkg::Q30_TWO_PI / 64'(COS_TABLE_SIZE);
         if (th > sscp_pkg::Q30_HALF_PI) begin
            cq = sscp_pkg::cos_quadrant(sscp_pkg::Q30_PI - th);
            rom[i*WEIGHT_W +: WEIGHT_W] = sscp_pkg::WEIGHT_ONE - cq;
         end else begin
            cq = sscp_pkg::cos_quadrant(th);
            rom[i*WEIGHT_W +: WEIGHT_W] = sscp_pkg::WEIGHT_ONE + cq;
         end
      end
      return rom;
   endfunction

   localparam logic [ROM_W-1:0] COS_ROM = build_cos_rom();

   // configuration registers
   logic [POS_W-1:0]   min_pulse_ff, min_pulse_in;
   logic [POS_W-1:0]   max_pulse_ff, max_pulse_in;
   logic [ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [ANGLE_W-1:0] end_angle_ff, end_angle_in;
   logic [DELAY_W-1:0] min_delay_ff, min_delay_in;
   logic [DELAY_W-1:0] max_delay_ff, max_delay_in;
   logic               enable_ff, enable_in;

   // sweep state and work registers
   sscp_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic                toward_end_ff, toward_end_in;
   logic                restart_ff, restart_in;
   logic [POS_W-1:0]    s_us_ff, s_us_in;
   logic [POS_W-1:0]    e_us_ff, e_us_in;
   logic [DELAY_W-1:0]  res_delay_ff, res_delay_in;
   logic                res_active_ff, res_active_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [DELAY_W-1:0]  rsp_delay_ff, rsp_delay_in;
   logic                rsp_active_ff, rsp_active_in;

   // shared arithmetic units
   logic                 mul_start, mul_done;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [2*MUL_W-1:0]   mul_product;
   logic                 div_start, div_done;
   logic [NUM_W-1:0]     div_num, div_quotient;
   logic [POS_W-1:0]     div_den;

   logic                 req_take, rsp_load;
   logic [ANGLE_W-1:0]   start_sat, end_sat;
   logic                 pulse_up, delay_up;
   logic [POS_W-1:0]     pulse_span, pulse_calc;
   logic [DELAY_W-1:0]   delay_span, delay_calc, delay_scaled;
   logic [POS_W-1:0]     tgt_first, tgt_move, pos_next;
   logic                 dir_move, dir_next;
   logic [POS_W-1:0]     lo_us, hi_us, span_us, dist_us;
   logic [NUM_W-1:0]     phase_num;
   logic [IDX_W-1:0]     rom_idx;
   logic [WEIGHT_W-1:0]  rom_word;
   logic                 bounds_equal, delays_equal;

   sscp_mul #(
      .A_W (MUL_W),
      .B_W (MUL_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   sscp_div #(
      .N_W (NUM_W),
      .D_W (POS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall = (state_ff != sscp_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == sscp_pkg::ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // angle to pulse width, saturating at a half turn
   assign start_sat = (start_angle_ff > ANGLE_W'(sscp_pkg::ANGLE_FULL)) ?
                      ANGLE_W'(sscp_pkg::ANGLE_FULL) : start_angle_ff;
   assign end_sat   = (end_angle_ff > ANGLE_W'(sscp_pkg::ANGLE_FULL)) ?
                      ANGLE_W'(sscp_pkg::ANGLE_FULL) : end_angle_ff;
   assign pulse_up   = (max_pulse_ff >= min_pulse_ff);
   assign pulse_span = pulse_up ? (max_pulse_ff - min_pulse_ff) : (min_pulse_ff - max_pulse_ff);
   assign pulse_calc = pulse_up ? (min_pulse_ff + div_quotient[POS_W-1:0])
                                : (min_pulse_ff - div_quotient[POS_W-1:0]);

   // delay scaling by the raised-cosine weight
   assign delay_up     = (max_delay_ff >= min_delay_ff);
   assign delay_span   = delay_up ? (max_delay_ff - min_delay_ff) : (min_delay_ff - max_delay_ff);
   assign delay_scaled = mul_product[2*MUL_W-1:MUL_W];
   assign delay_calc   = delay_up ? (min_delay_ff + delay_scaled) : (min_delay_ff - delay_scaled);
   assign delays_equal = (max_delay_ff == min_delay_ff);
   assign bounds_equal = (s_us_ff == e_us_ff);

   // one microsecond toward the target, flipping first when already there
   assign tgt_first = toward_end_ff ? e_us_ff : s_us_ff;
   assign dir_move  = toward_end_ff ^ (position_ff == tgt_first);
   assign tgt_move  = dir_move ? e_us_ff : s_us_ff;
   assign pos_next  = (position_ff < tgt_move) ? (position_ff + POS_W'(1))
                                               : (position_ff - POS_W'(1));
   assign dir_next  = dir_move ^ (pos_next == tgt_move);

   // phase distance, clamped into the span
   assign lo_us     = (s_us_ff < e_us_ff) ? s_us_ff : e_us_ff;
   assign hi_us     = (s_us_ff < e_us_ff) ? e_us_ff : s_us_ff;
   assign span_us   = hi_us - lo_us;
   always_comb begin
      dist_us = (position_ff < lo_us) ? '0 : (position_ff - lo_us);
      if (dist_us > span_us) begin
         dist_us = span_us;
      end
   end
   assign phase_num = NUM_W'(dist_us) * NUM_W'(COS_TABLE_SIZE);

   // a full-span index wraps to the table start
   assign rom_idx  = (div_quotient == NUM_W'(COS_TABLE_SIZE)) ? '0 : div_quotient[IDX_W-1:0];
   assign rom_word = COS_ROM[rom_idx*WEIGHT_W +: WEIGHT_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sscp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (req_restart || enable_ff) ? sscp_pkg::ST_MUL_S : sscp_pkg::ST_RESP;
            end
         end
         sscp_pkg::ST_MUL_S: begin
            if (mul_done) state_in = sscp_pkg::ST_DIV_S;
         end
         sscp_pkg::ST_DIV_S: begin
            if (div_done) state_in = restart_ff ? sscp_pkg::ST_RESP : sscp_pkg::ST_MUL_E;
         end
         sscp_pkg::ST_MUL_E: begin
            if (mul_done) state_in = sscp_pkg::ST_DIV_E;
         end
         sscp_pkg::ST_DIV_E: begin
            if (div_done) state_in = sscp_pkg::ST_MOVE;
         end
         sscp_pkg::ST_MOVE: begin
            state_in = (bounds_equal || delays_equal) ? sscp_pkg::ST_RESP : sscp_pkg::ST_INDEX;
         end
         sscp_pkg::ST_INDEX: begin
            state_in = sscp_pkg::ST_PHASE;
         end
         sscp_pkg::ST_PHASE: begin
            if (div_done) state_in = sscp_pkg::ST_SCALE;
         end
         sscp_pkg::ST_SCALE: begin
            if (mul_done) state_in = sscp_pkg::ST_RESP;
         end
         sscp_pkg::ST_RESP: begin
            if (rsp_load) state_in = sscp_pkg::ST_IDLE;
         end
         default: begin
            state_in = sscp_pkg::ST_IDLE;
         end
      endcase
   end

   // unit launches and operand selection
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         sscp_pkg::ST_IDLE: begin
            if (req_take && (req_restart || enable_ff)) begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(pulse_span);
               mul_b     = MUL_W'(start_sat);
            end
         end
         sscp_pkg::ST_MUL_S, sscp_pkg::ST_MUL_E: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = mul_product[NUM_W-1:0];
               div_den   = POS_W'(sscp_pkg::ANGLE_FULL);
            end
         end
         sscp_pkg::ST_DIV_S: begin
            if (div_done && !restart_ff) begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(pulse_span);
               mul_b     = MUL_W'(end_sat);
            end
         end
         sscp_pkg::ST_INDEX: begin
            div_start = 1'b1;
            div_num   = phase_num;
            div_den   = span_us;
         end
         sscp_pkg::ST_PHASE: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = delay_span;
               mul_b     = rom_word;
            end
         end
         default: begin
         end
      endcase
   end

   // sweep state and result fields
   always_comb begin
      position_in   = position_ff;
      toward_end_in = toward_end_ff;
      restart_in    = restart_ff;
      s_us_in       = s_us_ff;
      e_us_in       = e_us_ff;
      res_delay_in  = res_delay_ff;
      res_active_in = res_active_ff;
      case (state_ff)
         sscp_pkg::ST_IDLE: begin
            if (req_take) begin
               restart_in    = req_restart;
               res_delay_in  = '0;
               res_active_in = 1'b0;
            end
         end
         sscp_pkg::ST_DIV_S: begin
            if (div_done) begin
               s_us_in = pulse_calc;
               if (restart_ff) begin
                  position_in   = pulse_calc;
                  toward_end_in = 1'b1;
               end
            end
         end
         sscp_pkg::ST_DIV_E: begin
            if (div_done) e_us_in = pulse_calc;
         end
         sscp_pkg::ST_MOVE: begin
            if (!bounds_equal) begin
               position_in   = pos_next;
               toward_end_in = dir_next;
               res_active_in = 1'b1;
            end
            if (bounds_equal || delays_equal) begin
               res_delay_in = max_delay_ff;
            end
         end
         sscp_pkg::ST_SCALE: begin
            if (mul_done) res_delay_in = delay_calc;
         end
         default: begin
         end
      endcase
   end

   // output register: load when the slot is free or being drained
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;
      rsp_delay_in    = rsp_delay_ff;
      rsp_active_in   = rsp_active_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = position_ff;
         rsp_delay_in    = res_delay_ff;
         rsp_active_in   = res_active_ff;
      end
   end

   // register writes
   always_comb begin
      min_pulse_in   = min_pulse_ff;
      max_pulse_in   = max_pulse_ff;
      start_angle_in = start_angle_ff;
      end_angle_in   = end_angle_ff;
      min_delay_in   = min_delay_ff;
      max_delay_in   = max_delay_ff;
      enable_in      = enable_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sscp_pkg::CSR_MIN_PULSE: min_pulse_in   = csr_wdata[POS_W-1:0];
            sscp_pkg::CSR_MAX_PULSE: max_pulse_in   = csr_wdata[POS_W-1:0];
            sscp_pkg::CSR_START_ANG: start_angle_in = csr_wdata[ANGLE_W-1:0];
            sscp_pkg::CSR_END_ANG:   end_angle_in   = csr_wdata[ANGLE_W-1:0];
            sscp_pkg::CSR_MIN_DELAY: min_delay_in   = csr_wdata[DELAY_W-1:0];
            sscp_pkg::CSR_MAX_DELAY: max_delay_in   = csr_wdata[DELAY_W-1:0];
            sscp_pkg::CSR_ENABLE:    enable_in      = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff   <= POS_W'(544);
         max_pulse_ff   <= POS_W'(2400);
         start_angle_ff <= '0;
         end_angle_ff   <= ANGLE_W'(sscp_pkg::ANGLE_FULL);
         min_delay_ff   <= DELAY_W'(1000);
         max_delay_ff   <= DELAY_W'(10000);
         enable_ff      <= 1'b0;
         state_ff       <= sscp_pkg::ST_IDLE;
         position_ff    <= '0;
         toward_end_ff  <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         min_pulse_ff   <= min_pulse_in;
         max_pulse_ff   <= max_pulse_in;
         start_angle_ff <= start_angle_in;
         end_angle_ff   <= end_angle_in;
         min_delay_ff   <= min_delay_in;
         max_delay_ff   <= max_delay_in;
         enable_ff      <= enable_in;
         state_ff       <= state_in;
         position_ff    <= position_in;
         toward_end_ff  <= toward_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff      <= restart_in;
      s_us_ff         <= s_us_in;
      e_us_ff         <= e_us_in;
      res_delay_ff    <= res_delay_in;
      res_active_ff   <= res_active_in;
      rsp_position_ff <= rsp_position_in;
      rsp_delay_ff    <= rsp_delay_in;
      rsp_active_ff   <= rsp_active_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_us   = rsp_position_ff;
   assign rsp_step_delay_us = rsp_delay_ff;
   assign rsp_active        = rsp_active_ff;

`ifndef SYNTHESIS
   a_one_unit_launch: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider launched together");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("req not stalled after a beat was taken");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == sscp_pkg::ST_MUL_S || state_ff == sscp_pkg::ST_MUL_E ||
                    state_ff == sscp_pkg::ST_SCALE))
      else $error("multiplier finished outside a waiting state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sscp_pkg::ST_DIV_S || state_ff == sscp_pkg::ST_DIV_E ||
                    state_ff == sscp_pkg::ST_PHASE))
      else $error("divider finished outside a waiting state");

   a_position_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sscp_pkg::ST_MOVE && state_ff != sscp_pkg::ST_DIV_S)
      |=> $stable(position_ff))
      else $error("position changed outside move or restart load");
`endif

endmodule

>>> rtl/sscp_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Uses no package items; an A_W-bit adder is the only product arithmetic.
module sscp_mul #(
   parameter int A_W = 16,
   parameter int B_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [A_W-1:0]     mcand_ff, mcand_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [A_W:0]       upper;

   // add the multiplicand into the high half when the low bit is set
   assign upper = {1'b0, prod_ff[A_W+B_W-1:B_W]}
                + ({(A_W+1){prod_ff[0]}} & {1'b0, mcand_ff});

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {{A_W{1'b0}}, b};
         mcand_in = a;
         cnt_in   = CNT_W'(B_W);
      end else if (cnt_ff != '0) begin
         prod_in = {upper, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

>>> rtl/sscp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Uses no package items; divisor must be nonzero.
module sscp_div #(
   parameter int N_W = 21,
   parameter int D_W = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [D_W:0]     shifted;
   logic [D_W+1:0]   trial;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[N_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = !trial[D_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = CNT_W'(N_W);
      end else if (cnt_ff != '0) begin
         // keep the difference when the divisor fits, else restore
         rem_in  = fits ? trial[D_W-1:0] : shifted[D_W-1:0];
         quo_in  = {quo_ff[N_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> tb/sscp_sweep_checker.sv
`timescale 1ns / 1ps
// Sweep checker: watches the req, rsp and csr channels of the servo sweep block, predicts
// every rsp beat and compares it field by field. Depends on sscp_pkg for widths and csr codes.
module sscp_sweep_checker #(
   parameter int TABLE_SIZE = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_restart,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [sscp_pkg::POS_W-1:0]        rsp_position_us,
   input  logic [sscp_pkg::DELAY_W-1:0]      rsp_step_delay_us,
   input  logic                              rsp_active,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sscp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sscp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   import sscp_pkg::*;

   localparam logic [63:0] UNIT_Q30         = 64'd1073741824;
   localparam logic [63:0] FULL_TURN_Q30    = 64'd6746518852;
   localparam logic [63:0] HALF_TURN_Q30    = 64'd3373259426;
   localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int unsigned DEG_FULL         = 180;

   typedef struct packed {
      logic [POS_W-1:0]   position_us;
      logic [DELAY_W-1:0] step_delay_us;
      logic               active;
   } sweep_result_type;

   sweep_result_type   result_queue[$];
   int                 cos_rom[TABLE_SIZE];

   logic [11:0]        min_pulse;
   logic [11:0]        max_pulse;
   logic [7:0]         start_deg;
   logic [7:0]         end_deg;
   logic [15:0]        min_wait;
   logic [15:0]        max_wait;
   logic               enabled;
   logic [POS_W-1:0]   cur_pos;
   logic               heading_end;

   // Q30 cosine on the first quadrant, alternating series through x^14, result in Q15
   function automatic int cos_series(input logic [63:0] ang);
      logic [63:0] sq;
      logic [63:0] term;
      longint      acc;
      int          n;
      sq   = (ang * ang) >> 30;
      term = UNIT_Q30;
      acc  = longint'(UNIT_Q30);
      for (n = 1; n <= 7; n++) begin
         term = (term * sq) >> 30;
         term = term / 64'((2 * n - 1) * (2 * n));
         if ((n % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(UNIT_Q30)) begin
         acc = longint'(UNIT_Q30);
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) begin
         acc = 32767;
      end
      return int'(acc);
   endfunction

   initial begin
      logic [63:0] th;
      int          j;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         j = i;
         // fold the second half of the turn onto the first
         if (2 * j > TABLE_SIZE) begin
            j = TABLE_SIZE - j;
         end
         th = 64'(j) * FULL_TURN_Q30 / 64'(TABLE_SIZE);
         if (th > QUARTER_TURN_Q30) begin
            cos_rom[i] = -cos_series(HALF_TURN_Q30 - th);
         end else begin
            cos_rom[i] = cos_series(th);
         end
      end
   end

   function automatic logic [11:0] width_of(input logic [7:0] deg);
      int unsigned a;
      int unsigned lo_us;
      int unsigned hi_us;
      lo_us = min_pulse;
      hi_us = max_pulse;
      a     = deg;
      if (a > DEG_FULL) begin
         a = DEG_FULL;
      end
      if (hi_us >= lo_us) begin
         return 12'(lo_us + (hi_us - lo_us) * a / DEG_FULL);
      end
      return 12'(lo_us - (lo_us - hi_us) * a / DEG_FULL);
   endfunction

   function automatic logic [15:0] pacing_wait(input logic [11:0] pos, input int unsigned lo,
                                               input int unsigned hi);
      int unsigned       lo_w;
      int unsigned       hi_w;
      int unsigned       span;
      int unsigned       gap;
      int unsigned       slot;
      longint unsigned   weight;
      longint unsigned   diff;
      longint unsigned   scaled;
      lo_w = min_wait;
      hi_w = max_wait;
      if (hi_w == lo_w) begin
         return 16'(hi_w);
      end
      span = hi - lo;
      gap  = (pos < lo) ? 0 : pos - lo;
      if (gap > span) begin
         gap = span;
      end
      slot = gap * TABLE_SIZE / span;
      // a full turn wraps back to the first entry
      if (slot >= TABLE_SIZE) begin
         slot = 0;
      end
      weight = 32768 + cos_rom[slot];
      if (hi_w >= lo_w) begin
         diff   = hi_w - lo_w;
         scaled = (diff * weight) >> 16;
         return 16'(lo_w + scaled);
      end
      diff   = lo_w - hi_w;
      scaled = (diff * weight) >> 16;
      return 16'(lo_w - scaled);
   endfunction

   function automatic sweep_result_type advance_sweep(input logic restart);
      logic [11:0]      s_us;
      logic [11:0]      e_us;
      logic [11:0]      goal;
      int unsigned      lo;
      int unsigned      hi;
      sweep_result_type r;
      s_us            = width_of(start_deg);
      e_us            = width_of(end_deg);
      r.step_delay_us = '0;
      r.active        = 1'b0;
      if (restart) begin
         cur_pos     = s_us;
         heading_end = 1'b1;
      end else if (enabled) begin
         if (s_us == e_us) begin
            r.step_delay_us = max_wait;
         end else begin
            lo   = (s_us < e_us) ? s_us : e_us;
            hi   = (s_us < e_us) ? e_us : s_us;
            goal = heading_end ? e_us : s_us;
            // already parked on the target: turn around before moving
            if (cur_pos == goal) begin
               heading_end = !heading_end;
               goal        = heading_end ? e_us : s_us;
            end
            if (cur_pos < goal) begin
               cur_pos = cur_pos + 1'b1;
            end else begin
               cur_pos = cur_pos - 1'b1;
            end
            if (cur_pos == goal) begin
               heading_end = !heading_end;
            end
            r.step_delay_us = pacing_wait(cur_pos, lo, hi);
            r.active        = 1'b1;
         end
      end
      r.position_us = cur_pos;
      return r;
   endfunction

   always @(posedge clock) begin
      sweep_result_type want;
      int               errs;
      errs = fail_count;
      if (reset) begin
         min_pulse   = 12'd544;
         max_pulse   = 12'd2400;
         start_deg   = 8'd0;
         end_deg     = 8'd180;
         min_wait    = 16'd1000;
         max_wait    = 16'd10000;
         enabled     = 1'b0;
         cur_pos     = '0;
         heading_end = 1'b1;
         errs        = 0;
         result_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_PULSE: min_pulse = csr_wdata[11:0];
               CSR_MAX_PULSE: max_pulse = csr_wdata[11:0];
               CSR_START_ANG: start_deg = csr_wdata[7:0];
               CSR_END_ANG:   end_deg   = csr_wdata[7:0];
               CSR_MIN_DELAY: min_wait  = csr_wdata[15:0];
               CSR_MAX_DELAY: max_wait  = csr_wdata[15:0];
               CSR_ENABLE:    enabled   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (result_queue.size() == 0) begin
               $error("rsp beat with no expected result pending");
               errs++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_position_us !== want.position_us) begin
                  $error("position_us: expected %0d, actual %0d",
                         want.position_us, rsp_position_us);
                  errs++;
               end
               if (rsp_step_delay_us !== want.step_delay_us) begin
                  $error("step_delay_us: expected %0d, actual %0d",
                         want.step_delay_us, rsp_step_delay_us);
                  errs++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0d, actual %0d", want.active, rsp_active);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            result_queue.push_back(advance_sweep(req_restart));
         end
      end
      fail_count <= errs;
      pending    <= result_queue.size();
   end

endmodule

>>> tb/servo_sweep_cosine_pacing_tb.sv
`timescale 1ns / 1ps
// Top of the servo sweep testbench: clock, reset, csr setups, req beats and rsp stalls.
// Depends on sscp_pkg, servo_sweep_cosine_pacing and sscp_sweep_checker.
module servo_sweep_cosine_pacing_tb;
   import sscp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int ITEM_TARGET    = 1250;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic                    req_restart = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic [POS_W-1:0]        rsp_position_us;
   logic [DELAY_W-1:0]      rsp_step_delay_us;
   logic                    rsp_active;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index   = CSR_MIN_PULSE;
   logic [CSR_DATA_W-1:0]   csr_wdata   = '0;

   int                      send_idle_pct = 0;
   int                      rsp_stall_pct = 0;
   int                      quiet_cycles  = 0;
   int                      fail_count;
   int                      pending;

   always #4 clock = ~clock;

   servo_sweep_cosine_pacing dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position_us   (rsp_position_us),
      .rsp_step_delay_us (rsp_step_delay_us),
      .rsp_active        (rsp_active),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   sscp_sweep_checker u_sweep_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position_us   (rsp_position_us),
      .rsp_step_delay_us (rsp_step_delay_us),
      .rsp_active        (rsp_active),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // end the run once no beat has moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_reg(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_setup(input int unsigned min_p, input int unsigned max_p,
                             input int unsigned start_a, input int unsigned end_a,
                             input int unsigned min_d, input int unsigned max_d,
                             input int unsigned run);
      put_reg(CSR_MIN_PULSE, min_p);
      put_reg(CSR_MAX_PULSE, max_p);
      put_reg(CSR_START_ANG, start_a);
      put_reg(CSR_END_ANG, end_a);
      put_reg(CSR_MIN_DELAY, min_d);
      put_reg(CSR_MAX_DELAY, max_d);
      put_reg(CSR_ENABLE, run);
      csr_valid <= 1'b0;
   endtask

   task automatic send_beat(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and hold until every predicted rsp beat has arrived
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic int unsigned pick_edge(input int unsigned top_val);
      int unsigned r;
      r = $urandom_range(7);
      if (r == 0) begin
         return 0;
      end
      if (r == 1) begin
         return top_val;
      end
      return $urandom_range(top_val);
   endfunction

   initial begin
      int          items_sent;
      int          phase;
      int          n_items;
      int unsigned min_p;
      int unsigned max_p;
      int unsigned delta;
      int unsigned start_a;
      int unsigned end_a;
      int unsigned min_d;
      int unsigned max_d;
      int unsigned run;

      items_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, sweep stopped: a held step, then a restart that still applies
      send_beat(1'b0);
      send_beat(1'b1);
      settle();

      // narrow sweep with end angle beyond 180, full delay range: runs into the end and turns
      load_setup(1000, 1006, 0, 255, 0, 65535, 1);
      send_beat(1'b1);
      repeat (8) send_beat(1'b0);
      settle();

      // downward mapping, inverted delay limits; position starts outside the bounds
      load_setup(4095, 0, 90, 91, 65535, 0, 1);
      repeat (3) send_beat(1'b0);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);
      settle();

      // equal start and end widths hold the position
      load_setup(4095, 0, 45, 45, 777, 777, 1);
      repeat (2) send_beat(1'b0);
      settle();

      // equal delay limits bypass the cosine lookup
      load_setup(0, 4095, 0, 1, 777, 777, 1);
      send_beat(1'b1);
      repeat (3) send_beat(1'b0);
      settle();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 14;
               rsp_stall_pct = 14;
            end
         endcase
         min_p = pick_edge(4095);
         if ($urandom_range(3) != 0) begin
            // keep the width span short so the sweep turns around often
            delta = $urandom_range(48);
            if ($urandom_range(1) == 1) begin
               max_p = (min_p + delta > 4095) ? 4095 : min_p + delta;
            end else begin
               max_p = (min_p < delta) ? 0 : min_p - delta;
            end
         end else begin
            max_p = pick_edge(4095);
         end
         start_a = ($urandom_range(15) == 0) ? 255 : $urandom_range(200);
         end_a   = ($urandom_range(15) == 0) ? 255 : $urandom_range(200);
         min_d   = pick_edge(65535);
         max_d   = ($urandom_range(7) == 0) ? min_d : pick_edge(65535);
         run     = ($urandom_range(7) != 0) ? 1 : 0;
         load_setup(min_p, max_p, start_a, end_a, min_d, max_d, run);

         n_items = $urandom_range(40, 80);
         for (int k = 0; k < n_items; k++) begin
            if (k == 0) begin
               send_beat($urandom_range(3) != 0);
            end else begin
               send_beat($urandom_range(24) == 0);
            end
         end
         items_sent += n_items;
         settle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/sscp_pkg.sv
rtl/sscp_mul.sv
rtl/sscp_div.sv
rtl/servo_sweep_cosine_pacing.sv
tb/sscp_sweep_checker.sv
tb/servo_sweep_cosine_pacing_tb.sv
